@@ src/hcc_pkg.sv @@
// ----------------------------------------------------------------------------
// hcc_pkg: shared constants for the cubic Hermite curve evaluator
// Register indexes of the configuration port, pipeline depth and the
// guard-bit budget used by the per-axis datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package hcc_pkg;

  // Configuration register map.
  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_START_X     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_START_Y     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_START_TAN_X = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_START_TAN_Y = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_END_X       = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_END_Y       = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_END_TAN_X   = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_END_TAN_Y   = 3'd7;

  // Guard bits carried through the Horner steps: at most GUARD_MAX, fewer
  // when wide coordinates and parameters would blow up the intermediates.
  localparam int GUARD_BUDGET = 59;
  localparam int GUARD_MAX    = 8;

  // Register stages from input transfer to result strobe.
  localparam int PIPE_DEPTH = 8;

endpackage : hcc_pkg

`default_nettype wire

@@ src/hcc_axis.sv @@
// ----------------------------------------------------------------------------
// hcc_axis: one axis of the Hermite curve evaluator
// Builds the cubic coefficients from the control points and evaluates
// a*u^3 + b*u^2 + c*u + d in Horner form over seven register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module hcc_axis #(
  parameter int COORD_WIDTH     = 16,
  parameter int PARAM_FRAC_BITS = 16
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire logic signed [COORD_WIDTH-1:0] p0,
  input  wire logic signed [COORD_WIDTH-1:0] t0,
  input  wire logic signed [COORD_WIDTH-1:0] p1,
  input  wire logic signed [COORD_WIDTH-1:0] t1,
  input  wire logic [PARAM_FRAC_BITS:0]      u,
  output logic signed [COORD_WIDTH+1:0]      point
);
  import hcc_pkg::*;

  localparam int CW     = COORD_WIDTH;
  localparam int F      = PARAM_FRAC_BITS;
  localparam int G_RAW  = GUARD_BUDGET - CW - F;
  localparam int G      = (G_RAW < GUARD_MAX) ? G_RAW : GUARD_MAX;
  localparam int CF     = CW + 4;          // coefficient width
  localparam int QW     = CW + G + 5;      // Horner accumulator width
  localparam int UW     = F + 1;           // clamped parameter width
  localparam int PW     = QW + UW + 1;     // product width
  localparam int OW     = CW + 2;          // result width
  localparam int S1     = F - G;           // first rounding shift

  // Coefficients, recomputed every cycle from the control points.
  logic signed [CF-1:0] a_r, b_r, c_r, d_r;
  logic signed [CF-1:0] a_nxt, b_nxt, c_nxt, d_nxt;
  logic signed [CF-1:0] p0_e, t0_e, p1_e, t1_e;

  always_comb begin
    p0_e  = CF'(p0);
    t0_e  = CF'(t0);
    p1_e  = CF'(p1);
    t1_e  = CF'(t1);
    a_nxt = (p0_e <<< 1) + t0_e + t1_e - (p1_e <<< 1);
    b_nxt = (p1_e <<< 1) + p1_e - (p0_e <<< 1) - p0_e - (t0_e <<< 1) - t1_e;
    c_nxt = t0_e;
    d_nxt = p0_e;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= '0;
      b_r <= '0;
      c_r <= '0;
      d_r <= '0;
    end else begin
      a_r <= a_nxt;
      b_r <= b_nxt;
      c_r <= c_nxt;
      d_r <= d_nxt;
    end
  end

  // Datapath stages.
  logic [UW-1:0]        u1_r, u2_r, u3_r, u4_r;
  logic signed [PW-1:0] p1_r, p2_r, p3_r;
  logic signed [QW-1:0] q1_r, q2_r, q3_r;
  logic signed [OW-1:0] pt_r;

  logic signed [PW-1:0] m1_nxt, m2_nxt, m3_nxt;
  logic signed [PW-1:0] r1_sum, r2_sum, r3_sum;
  logic signed [QW-1:0] q1_nxt, q2_nxt, q3_nxt;
  logic signed [QW-1:0] r4_sum;
  logic signed [OW-1:0] pt_nxt;

  always_comb begin
    m1_nxt = PW'(QW'(a_r)) * $signed({1'b0, u});
    m2_nxt = PW'(q1_r) * $signed({1'b0, u2_r});
    m3_nxt = PW'(q2_r) * $signed({1'b0, u4_r});
  end

  generate
    if (S1 > 0) begin : g_rnd1
      always_comb begin
        r1_sum = p1_r + $signed(PW'(1) << (S1 - 1));
        q1_nxt = QW'(r1_sum >>> S1) + (QW'(b_r) <<< G);
      end
    end else begin : g_nornd1
      always_comb begin
        r1_sum = p1_r;
        q1_nxt = QW'(r1_sum) + (QW'(b_r) <<< G);
      end
    end
  endgenerate

  always_comb begin
    r2_sum = p2_r + $signed(PW'(1) << (F - 1));
    q2_nxt = QW'(r2_sum >>> F) + (QW'(c_r) <<< G);
    r3_sum = p3_r + $signed(PW'(1) << (F - 1));
    q3_nxt = QW'(r3_sum >>> F) + (QW'(d_r) <<< G);
    r4_sum = q3_r + $signed(QW'(1) << (G - 1));
    pt_nxt = OW'(r4_sum >>> G);
  end

  always_ff @(posedge clk) begin
    u1_r <= u;
    p1_r <= m1_nxt;
    u2_r <= u1_r;
    q1_r <= q1_nxt;
    u3_r <= u2_r;
    p2_r <= m2_nxt;
    u4_r <= u3_r;
    q2_r <= q2_nxt;
    p3_r <= m3_nxt;
    q3_r <= q3_nxt;
    pt_r <= pt_nxt;
  end

  assign point = pt_r;

endmodule : hcc_axis

`default_nettype wire

@@ src/hermite_cubic_curve_eval.sv @@
// ----------------------------------------------------------------------------
// hermite_cubic_curve_eval: 2-D cubic Hermite curve evaluator
// Holds the start/end points and tangents, clamps each parameter t to
// [0,1] and returns the curve point in signed Q14.4, one point per cycle.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                               Handshake
//  --------  ----------------------------------  ---------------------------
//  input     in_param                            start high, busy low
//  result    out_point_x, out_point_y            out_valid strobe, 1 cycle
//  config    cfg_index, cfg_data                 cfg_we, no wait
//
// Between a parameter's transfer and its result strobe lie the input
// register, the three multiply stages and three round-and-add stages of
// the Horner evaluation and the output register. A new parameter
// can be transferred in every cycle, so the block sustains one point per
// clock; busy therefore never rises. The receiver cannot stall the result
// strobe, so nothing is ever held back in the pipeline. Reset (rst_n low at
// a clock edge) clears all configuration registers, the coefficients and
// the valid bits; a curve with all points and tangents at zero results.
// A configuration write reaches the coefficient registers in the cycle after.
// ----------------------------------------------------------------------------
`default_nettype none

module hermite_cubic_curve_eval #(
  parameter int COORD_WIDTH     = 16,
  parameter int PARAM_FRAC_BITS = 16
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // Configuration write port.
  input  wire                                 cfg_we,
  input  wire logic [hcc_pkg::REG_IDX_W-1:0]  cfg_index,
  input  wire logic [COORD_WIDTH-1:0]         cfg_data,
  // Input channel.
  input  wire                                 start,
  output logic                                busy,
  input  wire logic signed [PARAM_FRAC_BITS+1:0] in_param,
  // Result channel.
  output logic                                out_valid,
  output logic signed [COORD_WIDTH+1:0]       out_point_x,
  output logic signed [COORD_WIDTH+1:0]       out_point_y
);
  import hcc_pkg::*;

  localparam int F  = PARAM_FRAC_BITS;
  localparam int UW = F + 1;

  // Configuration registers, reset to zero.
  logic [COORD_WIDTH-1:0] cfg_r [NUM_REGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg_r[i] <= '0;
      end
    end else if (cfg_we) begin
      cfg_r[cfg_index] <= cfg_data;
    end
  end

  // The pipeline always has room, so every start is a transfer.
  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Clamp t to [0, 1]: negative values go to zero, values above one (bit F
  // set together with any fraction bit) go to exactly one.
  logic [UW-1:0] u_nxt, u_r;

  always_comb begin
    if (in_param[F+1]) begin
      u_nxt = '0;
    end else if (in_param[F] && (|in_param[F-1:0])) begin
      u_nxt = UW'(1) << F;
    end else begin
      u_nxt = in_param[F:0];
    end
  end

  always_ff @(posedge clk) begin
    u_r <= u_nxt;
  end

  // Valid bits travel alongside the datapath stages.
  logic [PIPE_DEPTH-1:0] vld_r, vld_nxt;

  always_comb begin
    vld_nxt = {vld_r[PIPE_DEPTH-2:0], accept};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // One evaluator per axis; both see the same clamped parameter.
  hcc_axis #(
    .COORD_WIDTH    (COORD_WIDTH),
    .PARAM_FRAC_BITS(PARAM_FRAC_BITS)
  ) u_axis_x (
    .clk  (clk),
    .rst_n(rst_n),
    .p0   ($signed(cfg_r[REG_START_X])),
    .t0   ($signed(cfg_r[REG_START_TAN_X])),
    .p1   ($signed(cfg_r[REG_END_X])),
    .t1   ($signed(cfg_r[REG_END_TAN_X])),
    .u    (u_r),
    .point(out_point_x)
  );

  hcc_axis #(
    .COORD_WIDTH    (COORD_WIDTH),
    .PARAM_FRAC_BITS(PARAM_FRAC_BITS)
  ) u_axis_y (
    .clk  (clk),
    .rst_n(rst_n),
    .p0   ($signed(cfg_r[REG_START_Y])),
    .t0   ($signed(cfg_r[REG_START_TAN_Y])),
    .p1   ($signed(cfg_r[REG_END_Y])),
    .t1   ($signed(cfg_r[REG_END_TAN_Y])),
    .u    (u_r),
    .point(out_point_y)
  );

  assign out_valid = vld_r[PIPE_DEPTH-1];

endmodule : hermite_cubic_curve_eval

`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the 2-D cubic Hermite curve evaluator
// Loads curve end points and tangents through the write port, feeds curve
// parameters with random gaps and compares each result strobe against a
// fixed-point Horner predictor kept inside the bench.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hcc_pkg::*;

  // Widths at the default parameters of the block.
  localparam int COORD_W = 16;
  localparam int FRAC    = 16;
  localparam int PARAM_W = FRAC + 2;
  localparam int POINT_W = COORD_W + 2;
  localparam int ONE     = 1 << FRAC;

  // Guard bits follow the same budget rule as the datapath.
  localparam int GUARD_RAW = GUARD_BUDGET - COORD_W - FRAC;
  localparam int GUARD     = (GUARD_RAW < GUARD_MAX) ? GUARD_RAW : GUARD_MAX;

  // Extremes of a Q12.4 register and the same values seen on an 18-bit output.
  localparam logic [COORD_W-1:0]        Q_MAX = 16'h7FFF;
  localparam logic [COORD_W-1:0]        Q_MIN = 16'h8000;
  localparam logic signed [POINT_W-1:0] X_MAX = 18'sd32767;
  localparam logic signed [POINT_W-1:0] X_MIN = -18'sd32768;

  // Generous ceiling: every item behind the longest gap is far below this.
  localparam int CYCLE_LIMIT = 400000;

  localparam int RANDOM_PHASES    = 12;
  localparam int ITEMS_PER_PHASE  = 120;

  typedef struct packed {
    logic signed [POINT_W-1:0] x;
    logic signed [POINT_W-1:0] y;
  } curve_point_t;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  typedef struct packed {
    row_kind_t                 kind;
    logic [REG_IDX_W-1:0]      reg_index;
    logic [COORD_W-1:0]        reg_value;
    logic signed [PARAM_W-1:0] t;
    logic                      typed;
    curve_point_t              point;
  } stim_row_t;

  localparam curve_point_t NO_POINT = '0;

  // Clock and the block's inputs, all known from time zero.
  logic                      clk       = 1'b0;
  logic                      rst_n     = 1'b0;
  logic                      cfg_we    = 1'b0;
  logic [REG_IDX_W-1:0]      cfg_index = '0;
  logic [COORD_W-1:0]        cfg_data  = '0;
  logic                      start     = 1'b0;
  logic signed [PARAM_W-1:0] in_param  = '0;

  logic                      busy;
  logic                      out_valid;
  logic signed [POINT_W-1:0] out_point_x;
  logic signed [POINT_W-1:0] out_point_y;

  // Shadow copy of the curve registers and the points still owed by the block.
  logic signed [COORD_W-1:0] curve_regs [NUM_REGS] = '{default: '0};
  curve_point_t              pending_points [$];

  int unsigned mismatches     = 0;
  int unsigned params_sent    = 0;
  int unsigned points_checked = 0;
  int unsigned curve_settings = 0;
  int unsigned cycle_count    = 0;
  bit          no_gaps        = 1'b0;

  hermite_cubic_curve_eval dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .start       (start),
    .busy        (busy),
    .in_param    (in_param),
    .out_valid   (out_valid),
    .out_point_x (out_point_x),
    .out_point_y (out_point_y)
  );

  // 12 ns clock period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Curve point for one parameter, computed with the current register shadow.
  // The Hermite basis turns the four control values of an axis into the
  // coefficients a, b, c and d; the cubic is then evaluated in Horner form
  // with guard bits and round-to-nearest (ties upward) after every product.
  function automatic curve_point_t hermite_point(input logic signed [PARAM_W-1:0] t);
    longint       u;
    longint       p0, t0, p1, t1;
    longint       ka, kb, kc, kd;
    longint       acc;
    int           axis;
    curve_point_t pt;
    u = longint'(t);
    if (u < 0) u = 0;
    if (u > ONE) u = longint'(ONE);
    pt = '0;
    for (axis = 0; axis < 2; axis++) begin
      p0 = longint'(curve_regs[REG_START_X + axis]);
      t0 = longint'(curve_regs[REG_START_TAN_X + axis]);
      p1 = longint'(curve_regs[REG_END_X + axis]);
      t1 = longint'(curve_regs[REG_END_TAN_X + axis]);
      ka = 2 * p0 + t0 + t1 - 2 * p1;
      kb = -3 * p0 - 2 * t0 - t1 + 3 * p1;
      kc = t0;
      kd = p0;
      // The arithmetic shift of a signed longint floors, which is what the
      // rounding needs for negative intermediates.
      acc = ((ka * u + (64'sd1 <<< (FRAC - GUARD - 1))) >>> (FRAC - GUARD))
            + (kb <<< GUARD);
      acc = ((acc * u + (64'sd1 <<< (FRAC - 1))) >>> FRAC) + (kc <<< GUARD);
      acc = ((acc * u + (64'sd1 <<< (FRAC - 1))) >>> FRAC) + (kd <<< GUARD);
      acc = (acc + (64'sd1 <<< (GUARD - 1))) >>> GUARD;
      if (axis == 0) pt.x = acc[POINT_W-1:0];
      else           pt.y = acc[POINT_W-1:0];
    end
    return pt;
  endfunction

  // Writes one curve register once no point is outstanding. The write enable
  // is left high so that back-to-back writes never lower and raise it in the
  // same step; the next parameter offer lowers it.
  task automatic write_curve_reg(input logic [REG_IDX_W-1:0] index,
                                 input logic [COORD_W-1:0] value);
    start <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    curve_regs[index] = value;
    @(posedge clk);
  endtask

  // Offers one parameter after a random gap and waits for its transfer. The
  // expected point is either given by the caller or taken from the predictor.
  task automatic sample_curve(input logic signed [PARAM_W-1:0] t,
                              input logic typed, input curve_point_t typed_point);
    int unsigned gap;
    int unsigned sel;
    gap = 0;
    cfg_we <= 1'b0;
    if (!no_gaps) begin
      sel = $urandom_range(0, 99);
      if (sel < 50)      gap = 0;
      else if (sel < 90) gap = $urandom_range(1, 3);
      else               gap = $urandom_range(8, 40);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    in_param <= t;
    // busy is read before the edge's updates land, so it is the value the
    // block saw when it decided on the transfer.
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_points.push_back(typed ? typed_point : hermite_point(t));
    params_sent++;
  endtask

  // Result side: the strobe lasts one cycle and cannot be held off, so every
  // strobe seen at an edge is a transfer to check against the oldest point.
  always @(posedge clk) begin
    curve_point_t want;
    if (rst_n && out_valid) begin
      if (pending_points.size() == 0) begin
        $error("result strobe with no point pending: x=%0d y=%0d",
               out_point_x, out_point_y);
        mismatches++;
      end else begin
        want = pending_points.pop_front();
        points_checked++;
        if (out_point_x !== want.x) begin
          $error("point_x mismatch: expected %0d, actual %0d", want.x, out_point_x);
          mismatches++;
        end
        if (out_point_y !== want.y) begin
          $error("point_y mismatch: expected %0d, actual %0d", want.y, out_point_y);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d points outstanding",
               cycle_count, pending_points.size());
      $display("hermite_cubic_curve_eval test failed");
      $finish;
    end
  end

  initial begin
    stim_row_t                 directed_rows [$];
    logic signed [PARAM_W-1:0] t;
    logic [COORD_W-1:0]        value;
    int unsigned               sel;
    int                        phase;
    int                        n;
    int                        r;

    // Directed table. Right after reset every coefficient is zero, so any
    // parameter lands on the origin. Then two curves with every control
    // value at an extreme of its range: clamped parameters below zero must
    // give the start point and those above one the end point, and the
    // interior samples go through the predictor.
    directed_rows = '{
      '{ROW_SAMPLE, REG_START_X, 16'h0, 18'sd0,       1'b1, '{18'sd0, 18'sd0}},
      '{ROW_SAMPLE, REG_START_X, 16'h0, 18'sd131071,  1'b1, '{18'sd0, 18'sd0}},
      '{ROW_SAMPLE, REG_START_X, 16'h0, -18'sd131072, 1'b1, '{18'sd0, 18'sd0}},
      '{ROW_WRITE,  REG_START_X,     Q_MAX, 18'sd0, 1'b0, NO_POINT},
      '{ROW_WRITE,  REG_START_Y,     Q_MIN, 18'sd0, 1'b0, NO_POINT},
      '{ROW_WRITE,  REG_START_TAN_X, Q_MIN, 18'sd0, 1'b0, NO_POINT},
      '{ROW_WRITE,  REG_START_TAN_Y, Q_MAX, 18'sd0, 1'b0, NO_POINT},
      '{ROW_WRITE,  REG_END_X,       Q_MIN, 18'sd0, 1'b0, NO_POINT},
      '{ROW_WRITE,  REG_END_Y,       Q_MAX, 18'sd0, 1'b0, NO_POINT},
      '{ROW_WRITE,  REG_END_TAN_X,   Q_MAX, 18'sd0, 1'b0, NO_POINT},
      '{ROW_WRITE,  REG_END_TAN_Y,   Q_MIN, 18'sd0, 1'b0, NO_POINT},
      '{ROW_SAMPLE, REG_START_X, 16'h0, 18'sd0,       1'b1, '{X_MAX, X_MIN}},
      '{ROW_SAMPLE, REG_START_X, 16'h0, -18'sd1,      1'b1, '{X_MAX, X_MIN}},
      '{ROW_SAMPLE, REG_START_X, 16'h0, -18'sd131072, 1'b1, '{X_MAX, X_MIN}},
      '{ROW_SAMPLE, REG_START_X, 16'h0, 18'sd65536,   1'b1, '{X_MIN, X_MAX}},
      '{ROW_SAMPLE, REG_START_X, 16'h0, 18'sd65537,   1'b1, '{X_MIN, X_MAX}},
      '{ROW_SAMPLE, REG_START_X, 16'h0, 18'sd131071,  1'b1, '{X_MIN, X_MAX}},
      '{ROW_SAMPLE, REG_START_X, 16'h0, 18'sd1,       1'b0, NO_POINT},
      '{ROW_SAMPLE, REG_START_X, 16'h0, 18'sd32768,   1'b0, NO_POINT},
      '{ROW_SAMPLE, REG_START_X, 16'h0, 18'sd65535,   1'b0, NO_POINT},
      '{ROW_SAMPLE, REG_START_X, 16'h0, 18'sd21845,   1'b0, NO_POINT},
      '{ROW_SAMPLE, REG_START_X, 16'h0, 18'sd43690,   1'b0, NO_POINT},
      '{ROW_WRITE,  REG_START_X,     Q_MIN, 18'sd0, 1'b0, NO_POINT},
      '{ROW_WRITE,  REG_START_Y,     Q_MAX, 18'sd0, 1'b0, NO_POINT},
      '{ROW_WRITE,  REG_START_TAN_X, Q_MAX, 18'sd0, 1'b0, NO_POINT},
      '{ROW_WRITE,  REG_START_TAN_Y, Q_MIN, 18'sd0, 1'b0, NO_POINT},
      '{ROW_WRITE,  REG_END_X,       Q_MAX, 18'sd0, 1'b0, NO_POINT},
      '{ROW_WRITE,  REG_END_Y,       Q_MIN, 18'sd0, 1'b0, NO_POINT},
      '{ROW_WRITE,  REG_END_TAN_X,   Q_MIN, 18'sd0, 1'b0, NO_POINT},
      '{ROW_WRITE,  REG_END_TAN_Y,   Q_MAX, 18'sd0, 1'b0, NO_POINT},
      '{ROW_SAMPLE, REG_START_X, 16'h0, 18'sd0,       1'b1, '{X_MIN, X_MAX}},
      '{ROW_SAMPLE, REG_START_X, 16'h0, 18'sd65536,   1'b1, '{X_MAX, X_MIN}},
      '{ROW_SAMPLE, REG_START_X, 16'h0, 18'sd98304,   1'b1, '{X_MAX, X_MIN}},
      '{ROW_SAMPLE, REG_START_X, 16'h0, -18'sd65536,  1'b1, '{X_MIN, X_MAX}},
      '{ROW_SAMPLE, REG_START_X, 16'h0, 18'sd32768,   1'b0, NO_POINT},
      '{ROW_SAMPLE, REG_START_X, 16'h0, 18'sd16384,   1'b0, NO_POINT}
    };

    // Synchronous reset held low from time zero, then released for good.
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        write_curve_reg(directed_rows[i].reg_index, directed_rows[i].reg_value);
        if (directed_rows[i].reg_index == REG_END_TAN_Y) curve_settings++;
      end else begin
        sample_curve(directed_rows[i].t, directed_rows[i].typed,
                     directed_rows[i].point);
      end
    end

    // Random phases. Each one loads a fresh curve (the first two with every
    // register at its positive or negative extreme), then streams parameters.
    // Most parameters sit inside [0, 1], a few on its edges and the rest span
    // the whole 18-bit field so that both clamps get regular traffic. Every
    // third phase runs without gaps to keep the pipeline completely full.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      for (r = 0; r < NUM_REGS; r++) begin
        sel = $urandom_range(0, 99);
        if (phase == 0)      value = Q_MAX;
        else if (phase == 1) value = Q_MIN;
        else if (sel < 15)   value = Q_MAX;
        else if (sel < 30)   value = Q_MIN;
        else if (sel < 40)   value = '0;
        else                 value = COORD_W'($urandom_range(0, 16'hFFFF));
        write_curve_reg(r[REG_IDX_W-1:0], value);
      end
      curve_settings++;
      no_gaps = (phase % 3 == 2);
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
          t = PARAM_W'($urandom_range(0, ONE));
        end else if (sel < 80) begin
          case ($urandom_range(0, 3))
            0:       t = '0;
            1:       t = PARAM_W'(ONE);
            2:       t = PARAM_W'(1);
            default: t = PARAM_W'(ONE - 1);
          endcase
        end else begin
          t = PARAM_W'($urandom());
        end
        sample_curve(t, 1'b0, NO_POINT);
      end
    end
    no_gaps = 1'b0;

    // Drain: wait for every point owed, then keep clocking past the pipeline
    // depth so that a stray extra strobe would still be caught.
    start  <= 1'b0;
    cfg_we <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);

    $display("Run covered %0d parameter transfers across %0d curve settings,",
             params_sent, curve_settings);
    $display("with %0d points compared and %0d mismatches.", points_checked, mismatches);
    if (mismatches == 0) begin
      $display("hermite_cubic_curve_eval test passed");
    end else begin
      $display("hermite_cubic_curve_eval test failed");
    end
    $finish;
  end

endmodule : tb_top

@@ hermite_cubic_curve_eval.f @@
src/hcc_pkg.sv
src/hcc_axis.sv
src/hermite_cubic_curve_eval.sv
tb/tb_top.sv
